@@ sv/dttp_pkg.sv @@
// ----------------------------------------------------------------------------
// dttp_pkg
// Types, constants and the month table shared by the date-time text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dttp_pkg;

	localparam logic [7:0]  CH_END     = 8'h00;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_NINE    = 8'h39;
	localparam logic [15:0] YEAR_BASE  = 16'd2000;
	localparam logic [15:0] SHORT_YEAR = 16'd100;
	localparam logic [6:0]  FIELD_MAX  = 7'd99;
	localparam logic [2:0]  LAST_FIELD = 3'd5;
	localparam logic [2:0]  FIELD_SAT  = 3'd6;
	localparam int          NUM_SMALL  = 5;

	// Indexes into the small field store.
	localparam logic [2:0] IDX_MONTH  = 3'd0;
	localparam logic [2:0] IDX_DAY    = 3'd1;
	localparam logic [2:0] IDX_HOUR   = 3'd2;
	localparam logic [2:0] IDX_MINUTE = 3'd3;
	localparam logic [2:0] IDX_SECOND = 3'd4;

	// Snapshot of the stores taken when a result is produced.
	typedef struct packed {
		logic [15:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic        done;
	} rec_t;

	typedef struct packed {
		logic [15:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [2:0]  weekday;
		logic        month_error;
		logic        seconds_complete;
	} result_t;

	// Load enables of the weekday stages.
	typedef struct packed {
		logic s3;
		logic out;
	} stage_en_t;

	function automatic logic [2:0] month_offset(input logic [3:0] month);
		logic [2:0] off;
		case (month)
			4'd1:    off = 3'd0;
			4'd2:    off = 3'd3;
			4'd3:    off = 3'd3;
			4'd4:    off = 3'd6;
			4'd5:    off = 3'd1;
			4'd6:    off = 3'd4;
			4'd7:    off = 3'd6;
			4'd8:    off = 3'd2;
			4'd9:    off = 3'd5;
			4'd10:   off = 3'd0;
			4'd11:   off = 3'd3;
			4'd12:   off = 3'd5;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

	function automatic logic [6:0] sat_field(input logic [15:0] v);
		return (v > 16'(FIELD_MAX)) ? FIELD_MAX : v[6:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/dttp_parse.sv @@
// ----------------------------------------------------------------------------
// dttp_parse
// Character parser: digit accumulator, field stores and result snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module dttp_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,      // character in ch leaves the input stage
	input  wire logic          load_s2,   // snapshot register may be written
	input  wire logic [7:0]    ch,
	output logic               emit,
	output dttp_pkg::rec_t     rec_s2
);
	import dttp_pkg::*;

	logic [15:0] acc_q, acc_n, acc_base, acc_mul;
	logic        parity_q, parity_n;
	logic [2:0]  fidx_q, fidx_n;
	logic [4:0]  stored_q, stored_n;
	logic        skip_q, skip_n;
	logic [15:0] year_q, year_n;
	logic [6:0]  small_q [NUM_SMALL];
	logic [6:0]  small_n [NUM_SMALL];
	logic        is_digit, storing, done;
	logic [3:0]  digit;
	logic [2:0]  prev_idx, small_idx;
	rec_t        snap;

	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit     = 4'(ch - CH_ZERO);
	assign prev_idx  = fidx_q - 3'd1;
	assign small_idx = fidx_q - 3'd2;
	assign storing   = (fidx_q >= 3'd1) && (fidx_q <= LAST_FIELD) && !stored_q[prev_idx];
	assign acc_base  = storing ? 16'd0 : acc_q;
	assign acc_mul   = {acc_base[12:0], 3'b000} + {acc_base[14:0], 1'b0} + {12'd0, digit};

	always_comb begin
		acc_n    = acc_q;
		parity_n = parity_q;
		fidx_n   = fidx_q;
		stored_n = stored_q;
		skip_n   = skip_q;
		year_n   = year_q;
		small_n  = small_q;
		emit     = 1'b0;
		done     = 1'b0;
		if (ch == CH_END) begin
			emit     = !skip_q;
			skip_n   = 1'b0;
			acc_n    = 16'd0;
			parity_n = 1'b0;
			fidx_n   = 3'd0;
			stored_n = 5'd0;
		end else if (skip_q) begin
			// Tail of a completed text is dropped until the end byte.
		end else if (!is_digit) begin
			if (fidx_q < FIELD_SAT) begin
				fidx_n = fidx_q + 3'd1;
			end
		end else begin
			parity_n = !parity_q;
			if (fidx_q <= LAST_FIELD) begin
				if (storing) begin
					stored_n[prev_idx] = 1'b1;
					if (fidx_q == 3'd1) begin
						year_n = (acc_q < SHORT_YEAR) ? acc_q + YEAR_BASE : acc_q;
					end else begin
						small_n[small_idx] = sat_field(acc_q);
					end
				end
				acc_n = acc_mul;
				// A seconds digit that makes the digit count of the text even closes the text.
				if (fidx_q == LAST_FIELD && parity_q) begin
					small_n[IDX_SECOND] = sat_field(acc_mul);
					skip_n = 1'b1;
					emit   = 1'b1;
					done   = 1'b1;
				end
			end
		end
	end

	always_comb begin
		snap.year   = year_n;
		snap.month  = small_n[IDX_MONTH];
		snap.day    = small_n[IDX_DAY];
		snap.hour   = small_n[IDX_HOUR];
		snap.minute = small_n[IDX_MINUTE];
		snap.second = small_n[IDX_SECOND];
		snap.done   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			parity_q <= 1'b0;
			fidx_q   <= '0;
			stored_q <= '0;
			skip_q   <= 1'b0;
			year_q   <= '0;
			for (int i = 0; i < NUM_SMALL; i++) begin
				small_q[i] <= '0;
			end
		end else if (take) begin
			acc_q    <= acc_n;
			parity_q <= parity_n;
			fidx_q   <= fidx_n;
			stored_q <= stored_n;
			skip_q   <= skip_n;
			year_q   <= year_n;
			small_q  <= small_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			rec_s2 <= snap;
		end
	end

endmodule

`default_nettype wire

@@ sv/dttp_weekday.sv @@
// ----------------------------------------------------------------------------
// dttp_weekday
// Two-stage weekday calculation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dttp_weekday (
	input  wire logic                clk,
	input  wire dttp_pkg::stage_en_t en,
	input  wire dttp_pkg::rec_t      rec_s2,
	output dttp_pkg::result_t        res_q
);
	import dttp_pkg::*;

	// Stage 3: year mod 100 by reciprocal multiply, shifted into 100..199 past 1999.
	logic [32:0] cent_prod;
	logic [9:0]  cent;
	logic [15:0] cent_x100, rem100;
	logic [7:0]  yl;
	rec_t        rec_s3;
	logic [7:0]  yl_s3;

	assign cent_prod = {17'd0, rec_s2.year} * 33'd83887;
	assign cent      = cent_prod[32:23];
	assign cent_x100 = 16'({cent, 6'd0}) + 16'({cent, 5'd0}) + 16'({cent, 2'd0});
	assign rem100    = rec_s2.year - cent_x100;
	assign yl        = {1'b0, rem100[6:0]} + ((rec_s2.year >= YEAR_BASE) ? 8'd100 : 8'd0);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rec_s3 <= rec_s2;
			yl_s3  <= yl;
		end
	end

	// Output stage: sum of the terms, then mod 7 by reciprocal multiply.
	logic        bad, leap;
	logic [8:0]  wsum;
	logic [18:0] q7_prod;
	logic [6:0]  q7;
	logic [8:0]  q7_x7, rem7;
	result_t     res_n;

	assign bad     = (rec_s3.month == 7'd0) || (rec_s3.month > 7'd12);
	assign leap    = (yl_s3[1:0] == 2'b00) && (rec_s3.month < 7'd3);
	assign wsum    = {1'b0, yl_s3} + {3'd0, yl_s3[7:2]} + {2'd0, rec_s3.day}
	               + {6'd0, month_offset(rec_s3.month[3:0])} + (leap ? 9'd6 : 9'd0);
	assign q7_prod = {10'd0, wsum} * 19'd586;
	assign q7      = q7_prod[18:12];
	assign q7_x7   = {q7, 2'b00} + {1'b0, q7, 1'b0} + {2'd0, q7};
	assign rem7    = wsum - q7_x7;

	always_comb begin
		res_n.year             = rec_s3.year;
		res_n.month            = rec_s3.month;
		res_n.day              = rec_s3.day;
		res_n.hour             = rec_s3.hour;
		res_n.minute           = rec_s3.minute;
		res_n.second           = rec_s3.second;
		res_n.weekday          = bad ? 3'd0 : rem7[2:0];
		res_n.month_error      = bad;
		res_n.seconds_complete = rec_s3.done;
	end

	always_ff @(posedge clk) begin
		if (en.out) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire

@@ sv/date_time_text_parser_top.sv @@
// ----------------------------------------------------------------------------
// date_time_text_parser_top
// Splits a date-time text into its fields and adds the day of the week.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tdata[7:0]  = ch
//  m_axis    out  tdata[55:0] = year, month, day, hour, minute, second,
//                               weekday, month_error, seconds_complete
//
// One character is taken per cycle while s_axis_tready is high. A result
// for the closing character passes the input register, parse and snapshot,
// year remainder, weekday and result register. Each stage holds while the
// stage after it is full and stalled, and empty stages fill up, so a stall
// on m_axis reaches s_axis only once every stage is occupied.
// Reset clears the parser state, the stores and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module date_time_text_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [15:0] year, [22:16] month, [29:23] day, [36:30] hour, [43:37] minute,
	// [50:44] second, [53:51] weekday, [54] month_error, [55] seconds_complete
	output logic [55:0]      m_axis_tdata
);
	import dttp_pkg::*;

	logic       v1_q, v2_q, v3_q, vo_q;
	logic       ready_1, ready_2, ready_3, ready_o;
	logic [7:0] ch_s1;
	logic       emit;
	rec_t       rec_s2;
	result_t    res_q;
	stage_en_t  en;

	assign ready_o = !vo_q || m_axis_tready;
	assign ready_3 = !v3_q || ready_o;
	assign ready_2 = !v2_q || ready_3;
	assign ready_1 = !v1_q || ready_2;
	assign s_axis_tready = ready_1;

	assign en = '{s3: ready_3, out: ready_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (ready_1) begin
				v1_q <= s_axis_tvalid;
			end
			if (ready_2) begin
				v2_q <= v1_q && emit;
			end
			if (ready_3) begin
				v3_q <= v2_q;
			end
			if (ready_o) begin
				vo_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_1) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	dttp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (v1_q && ready_2),
		.load_s2 (ready_2),
		.ch      (ch_s1),
		.emit    (emit),
		.rec_s2  (rec_s2)
	);

	dttp_weekday u_weekday (
		.clk    (clk),
		.en     (en),
		.rec_s2 (rec_s2),
		.res_q  (res_q)
	);

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = {res_q.seconds_complete, res_q.month_error, res_q.weekday,
	                        res_q.second, res_q.minute, res_q.hour, res_q.day,
	                        res_q.month, res_q.year};

	// A month out of range always forces Sunday.
	a_bad_month: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[54]) |-> (m_axis_tdata[53:51] == 3'd0))
		else $error("weekday not forced to zero on a bad month");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[53:51] <= 3'd6))
		else $error("weekday out of range");

	// Input back-pressure only when the whole pipeline is full behind a stall.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && v1_q && v2_q && v3_q))
		else $error("input stalled without a full, stalled pipeline");

	// A held snapshot is not lost while its next stage is blocked.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !ready_3) |=> v2_q)
		else $error("snapshot dropped during a stall");

endmodule

`default_nettype wire
